[hdl/mf3_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mf3_pkg
// Shared constants and types for the 3x3 median filter (valid region).
// ----------------------------------------------------------------------------
package mf3_pkg;

    // default sizes handed to the top level
    localparam int DEF_MAX_COLS   = 1024;
    localparam int DEF_MAX_ROWS   = 65535;
    localparam int DEF_PIXEL_BITS = 32;

    // window geometry
    localparam int WIN_SIZE   = 3;
    localparam int WIN_TAPS   = WIN_SIZE * WIN_SIZE;
    localparam int MIN_DIM    = WIN_SIZE;
    localparam int EMIT_START = WIN_SIZE - 1;

    // port widths fixed by the item format
    localparam int PIX_W       = 32;
    localparam int OUT_ROW_W   = 16;
    localparam int OUT_COL_W   = 10;
    localparam int OUT_TDATA_W = 64;
    localparam int CFG_ADDR_W  = 1;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_WIDTH_W = 11;

    // reset values of the configuration registers
    localparam logic [CFG_WIDTH_W-1:0] RST_IMAGE_WIDTH  = 11'd8;
    localparam logic [CFG_DATA_W-1:0]  RST_IMAGE_HEIGHT = 16'd5;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_IMAGE_HEIGHT = 1'd1;

    // position info carried with an item through the pipeline
    typedef struct packed {
        logic                 emit;
        logic                 last;
        logic [OUT_ROW_W-1:0] row;
        logic [OUT_COL_W-1:0] col;
    } pos_t;

endpackage

[hdl/mf3_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mf3_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module mf3_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[hdl/mf3_scan.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mf3_scan
// Frame size registers and raster position counters. Gives the position of
// the item being accepted and the line-store column it uses.
// ----------------------------------------------------------------------------
module mf3_scan #(
    parameter int MAX_COLS = mf3_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = mf3_pkg::DEF_MAX_ROWS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [mf3_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [mf3_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                              accept,
    output logic [$clog2(MAX_COLS)-1:0]       col_addr,
    output mf3_pkg::pos_t                     pos
);

    localparam int COL_W = $clog2(MAX_COLS);
    localparam int WC_W  = $clog2(MAX_COLS + 1);
    localparam int ROW_W = $clog2(MAX_ROWS + 1);

    logic [mf3_pkg::CFG_WIDTH_W-1:0] width_reg;
    logic [mf3_pkg::CFG_DATA_W-1:0]  height_reg;
    logic [COL_W-1:0]                col_reg, col_next;
    logic [ROW_W-1:0]                row_reg, row_next;

    logic [WC_W-1:0]  eff_w;
    logic [ROW_W-1:0] eff_h;
    logic [15:0]      wide_w;
    logic [COL_W-1:0] c;
    logic [ROW_W-1:0] r;
    logic [ROW_W:0]   r_pre, r_inc;
    logic [WC_W-1:0]  c_inc;
    logic [COL_W-1:0] c_off;
    logic [ROW_W-1:0] r_off;

    // clamp frame size to the supported range
    always_comb
    begin
        wide_w = 16'(width_reg);
        if (wide_w < 16'(mf3_pkg::MIN_DIM))
            eff_w = WC_W'(mf3_pkg::MIN_DIM);
        else if (wide_w > 16'(MAX_COLS))
            eff_w = WC_W'(MAX_COLS);
        else
            eff_w = WC_W'(wide_w);

        if (height_reg < 16'(mf3_pkg::MIN_DIM))
            eff_h = ROW_W'(mf3_pkg::MIN_DIM);
        else if (height_reg > 16'(MAX_ROWS))
            eff_h = ROW_W'(MAX_ROWS);
        else
            eff_h = ROW_W'(height_reg);
    end

    // position of this item; counters left past a shrunken frame wrap first
    always_comb
    begin
        if (WC_W'(col_reg) >= eff_w)
        begin
            c     = '0;
            r_pre = (ROW_W+1)'(row_reg) + 1'b1;
        end
        else
        begin
            c     = col_reg;
            r_pre = (ROW_W+1)'(row_reg);
        end
        r = (r_pre >= (ROW_W+1)'(eff_h)) ? '0 : r_pre[ROW_W-1:0];

        c_inc = WC_W'(c) + 1'b1;
        r_inc = (ROW_W+1)'(r) + 1'b1;
        if (c_inc >= eff_w)
        begin
            col_next = '0;
            row_next = (r_inc >= (ROW_W+1)'(eff_h)) ? '0 : r_inc[ROW_W-1:0];
        end
        else
        begin
            col_next = c_inc[COL_W-1:0];
            row_next = r;
        end

        c_off = c - COL_W'(mf3_pkg::EMIT_START);
        r_off = r - ROW_W'(mf3_pkg::EMIT_START);

        pos.emit = (r >= ROW_W'(mf3_pkg::EMIT_START)) && (c >= COL_W'(mf3_pkg::EMIT_START));
        pos.last = (c_inc == eff_w) && (r_inc == (ROW_W+1)'(eff_h));
        pos.row  = mf3_pkg::OUT_ROW_W'(r_off);
        pos.col  = mf3_pkg::OUT_COL_W'(c_off);
        col_addr = c;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= mf3_pkg::RST_IMAGE_WIDTH;
            height_reg <= mf3_pkg::RST_IMAGE_HEIGHT;
            col_reg    <= '0;
            row_reg    <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_addr)
                    mf3_pkg::CFG_IMAGE_WIDTH:
                        width_reg <= cfg_wdata[mf3_pkg::CFG_WIDTH_W-1:0];
                    mf3_pkg::CFG_IMAGE_HEIGHT:
                        height_reg <= cfg_wdata;
                    default:
                        ;
                endcase
            end
            if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
        end
    end

endmodule

[hdl/mf3_window.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mf3_window
// Two line stores and the 3x3 window. Stage 1 waits on the line-store read,
// stage 2 is the window itself, shifted once per item.
// ----------------------------------------------------------------------------
module mf3_window #(
    parameter int MAX_COLS   = mf3_pkg::DEF_MAX_COLS,
    parameter int PIXEL_BITS = mf3_pkg::DEF_PIXEL_BITS
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         in_valid,
    output logic                                         in_ready,
    input  logic [PIXEL_BITS-1:0]                        pixel,
    input  logic [$clog2(MAX_COLS)-1:0]                  col_addr,
    input  mf3_pkg::pos_t                                pos,
    output logic                                         win_valid,
    input  logic                                         win_ready,
    output logic [mf3_pkg::WIN_TAPS-1:0][PIXEL_BITS-1:0] window,
    output mf3_pkg::pos_t                                win_pos
);

    localparam int COL_W = $clog2(MAX_COLS);
    localparam int WS    = mf3_pkg::WIN_SIZE;

    logic                  s1_valid_reg;
    logic [PIXEL_BITS-1:0] s1_pix_reg;
    logic [COL_W-1:0]      s1_addr_reg;
    mf3_pkg::pos_t         s1_pos_reg;

    logic                  s2_valid_reg;
    mf3_pkg::pos_t         s2_pos_reg;
    logic [mf3_pkg::WIN_TAPS-1:0][PIXEL_BITS-1:0] win_reg, win_next;

    logic                  accept;
    logic                  s2_ready;
    logic                  s1_adv;
    logic [PIXEL_BITS-1:0] upper_rd, lower_rd;

    assign s2_ready = !s2_valid_reg || win_ready;
    assign in_ready = !s1_valid_reg || s2_ready;
    assign accept   = in_valid && in_ready;
    assign s1_adv   = s1_valid_reg && s2_ready;

    // upper holds row r-2, lower row r-1; each item pushes its column up
    mf3_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_COLS)) u_line_upper (
        .clk     (clk),
        .wr_en   (s1_adv),
        .wr_addr (s1_addr_reg),
        .wr_data (lower_rd),
        .rd_en   (accept),
        .rd_addr (col_addr),
        .rd_data (upper_rd)
    );

    mf3_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_COLS)) u_line_lower (
        .clk     (clk),
        .wr_en   (s1_adv),
        .wr_addr (s1_addr_reg),
        .wr_data (s1_pix_reg),
        .rd_en   (accept),
        .rd_addr (col_addr),
        .rd_data (lower_rd)
    );

    // taps are [row*3 + col], column 2 newest
    always_comb
    begin
        win_next = win_reg;
        for (int i = 0; i < WS; i++)
        begin
            for (int j = 0; j < WS - 1; j++)
            begin
                win_next[i*WS + j] = win_reg[i*WS + j + 1];
            end
        end
        win_next[WS - 1]       = upper_rd;
        win_next[2*WS - 1]     = lower_rd;
        win_next[WS*WS - 1]    = s1_pix_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            win_reg      <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg && s1_pos_reg.emit;
            end
            if (s1_adv)
            begin
                win_reg <= win_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg  <= pixel;
            s1_addr_reg <= col_addr;
            s1_pos_reg  <= pos;
        end
        if (s1_adv)
        begin
            s2_pos_reg <= s1_pos_reg;
        end
    end

    assign win_valid = s2_valid_reg;
    assign window    = win_reg;
    assign win_pos   = s2_pos_reg;

endmodule

[hdl/mf3_median.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mf3_median
// Nine-input median in three registered stages: sort each column, then
// max of lows / median of middles / min of highs, then median of those.
// ----------------------------------------------------------------------------
module mf3_median #(
    parameter int PIXEL_BITS = mf3_pkg::DEF_PIXEL_BITS
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         in_valid,
    output logic                                         in_ready,
    input  logic [mf3_pkg::WIN_TAPS-1:0][PIXEL_BITS-1:0] window,
    input  mf3_pkg::pos_t                                in_pos,
    output logic                                         out_valid,
    input  logic                                         out_ready,
    output logic [mf3_pkg::PIX_W-1:0]                    median,
    output mf3_pkg::pos_t                                out_pos
);

    localparam int WS = mf3_pkg::WIN_SIZE;

    typedef logic [PIXEL_BITS-1:0] pix_t;
    typedef logic [WS-1:0][PIXEL_BITS-1:0] trio_t;

    function automatic pix_t min2(input pix_t a, input pix_t b);
        return ($signed(a) < $signed(b)) ? a : b;
    endfunction

    function automatic pix_t max2(input pix_t a, input pix_t b);
        return ($signed(a) < $signed(b)) ? b : a;
    endfunction

    // ascending: [0] low, [2] high
    function automatic trio_t sort3(input pix_t a, input pix_t b, input pix_t c);
        pix_t  x0, x1, y1;
        trio_t t;
        x0   = min2(a, b);
        x1   = max2(a, b);
        y1   = min2(x1, c);
        t[2] = max2(x1, c);
        t[0] = min2(x0, y1);
        t[1] = max2(x0, y1);
        return t;
    endfunction

    function automatic pix_t med3(input pix_t a, input pix_t b, input pix_t c);
        return max2(min2(a, b), min2(max2(a, b), c));
    endfunction

    logic                  s3_valid_reg, s4_valid_reg, out_valid_reg;
    trio_t [WS-1:0]        s3_cols_reg, s3_cols_next;
    trio_t                 s4_trio_reg, s4_trio_next;
    logic [mf3_pkg::PIX_W-1:0] median_reg;
    mf3_pkg::pos_t         s3_pos_reg, s4_pos_reg, out_pos_reg;
    pix_t                  med_pix;

    logic out_free, s4_ready, s3_ready;

    assign out_free = !out_valid_reg || out_ready;
    assign s4_ready = !s4_valid_reg || out_free;
    assign s3_ready = !s3_valid_reg || s4_ready;
    assign in_ready = s3_ready;

    always_comb
    begin
        for (int k = 0; k < WS; k++)
        begin
            s3_cols_next[k] = sort3(window[k], window[WS + k], window[2*WS + k]);
        end
        s4_trio_next[0] = max2(max2(s3_cols_reg[0][0], s3_cols_reg[1][0]), s3_cols_reg[2][0]);
        s4_trio_next[1] = med3(s3_cols_reg[0][1], s3_cols_reg[1][1], s3_cols_reg[2][1]);
        s4_trio_next[2] = min2(min2(s3_cols_reg[0][2], s3_cols_reg[1][2]), s3_cols_reg[2][2]);
        med_pix = med3(s4_trio_reg[0], s4_trio_reg[1], s4_trio_reg[2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s3_ready)
                s3_valid_reg <= in_valid;
            if (s4_ready)
                s4_valid_reg <= s3_valid_reg;
            if (out_free)
                out_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_ready && in_valid)
        begin
            s3_cols_reg <= s3_cols_next;
            s3_pos_reg  <= in_pos;
        end
        if (s4_ready && s3_valid_reg)
        begin
            s4_trio_reg <= s4_trio_next;
            s4_pos_reg  <= s3_pos_reg;
        end
        if (out_free && s4_valid_reg)
        begin
            median_reg  <= mf3_pkg::PIX_W'($signed(med_pix));
            out_pos_reg <= s4_pos_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign median    = median_reg;
    assign out_pos   = out_pos_reg;

endmodule

[hdl/median_filter_3x3_valid_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// median_filter_3x3_valid_unit
// Pipeline: a result shows on m_tvalid once its pixel has passed the line-store
// read, window, column sort, merge and output registers.
// Throughput: one pixel per cycle; each stage holds on backpressure alone.
// Reset: counters to zero, window to zero, size to 8 x 5; line stores keep
// their contents and are not cleared.
// ----------------------------------------------------------------------------
module median_filter_3x3_valid_unit #(
    parameter int MAX_COLS   = mf3_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS   = mf3_pkg::DEF_MAX_ROWS,
    parameter int PIXEL_BITS = mf3_pkg::DEF_PIXEL_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [mf3_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [mf3_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [mf3_pkg::PIX_W-1:0]          s_tdata,   // [31:0] pixel
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [31:0] median_value, [47:32] out_row, [57:48] out_col, [63:58] zero
    output logic [mf3_pkg::OUT_TDATA_W-1:0]    m_tdata,
    output logic                               m_tlast    // frame_last
);

    localparam int PAD_W = mf3_pkg::OUT_TDATA_W - mf3_pkg::PIX_W
                           - mf3_pkg::OUT_ROW_W - mf3_pkg::OUT_COL_W;

    logic [$clog2(MAX_COLS)-1:0]                  col_addr;
    mf3_pkg::pos_t                                scan_pos, win_pos, out_pos;
    logic                                         win_valid, win_ready;
    logic [mf3_pkg::WIN_TAPS-1:0][PIXEL_BITS-1:0] window;
    logic [mf3_pkg::PIX_W-1:0]                    median;

    mf3_scan #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .accept    (s_tvalid && s_tready),
        .col_addr  (col_addr),
        .pos       (scan_pos)
    );

    mf3_window #(.MAX_COLS(MAX_COLS), .PIXEL_BITS(PIXEL_BITS)) u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .pixel     (s_tdata[PIXEL_BITS-1:0]),
        .col_addr  (col_addr),
        .pos       (scan_pos),
        .win_valid (win_valid),
        .win_ready (win_ready),
        .window    (window),
        .win_pos   (win_pos)
    );

    mf3_median #(.PIXEL_BITS(PIXEL_BITS)) u_median (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (win_valid),
        .in_ready  (win_ready),
        .window    (window),
        .in_pos    (win_pos),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .median    (median),
        .out_pos   (out_pos)
    );

    assign m_tdata = {{PAD_W{1'b0}}, out_pos.col, out_pos.row, median};
    assign m_tlast = out_pos.last;

endmodule

[dv/median_window_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// median_window_checker
// Watches the pixel, result and register channels of the 3x3 median filter,
// keeps its own copy of the line stores, window and frame counters, and
// compares every result item field by field with the predicted median and
// position. Mismatches and stray results are counted in err_count.
// ----------------------------------------------------------------------------
module median_window_checker #(
    parameter int MAX_COLS = mf3_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = mf3_pkg::DEF_MAX_ROWS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [mf3_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [mf3_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                               s_tvalid,
    input  logic                               s_tready,
    input  logic [mf3_pkg::PIX_W-1:0]          s_tdata,   // [31:0] pixel
    input  logic                               m_tvalid,
    input  logic                               m_tready,
    // [31:0] median_value, [47:32] out_row, [57:48] out_col, [63:58] zero
    input  logic [mf3_pkg::OUT_TDATA_W-1:0]    m_tdata,
    input  logic                               m_tlast,   // frame_last
    output int                                 err_count,
    output int                                 pending
);
    import mf3_pkg::*;

    localparam int ROW_LSB = PIX_W;
    localparam int COL_LSB = PIX_W + OUT_ROW_W;
    localparam int PAD_LSB = PIX_W + OUT_ROW_W + OUT_COL_W;

    typedef struct packed {
        logic [PIX_W-1:0]     value;
        logic [OUT_ROW_W-1:0] row;
        logic [OUT_COL_W-1:0] col;
        logic                 last;
    } median_item_t;

    median_item_t           median_q[$];
    logic [PIX_W-1:0]       row_above2 [MAX_COLS];
    logic [PIX_W-1:0]       row_above1 [MAX_COLS];
    logic [PIX_W-1:0]       taps [WIN_TAPS];   // [row * 3 + col], col 2 newest
    int unsigned            col_pos;
    int unsigned            row_pos;
    logic [CFG_WIDTH_W-1:0] width_reg;
    logic [CFG_DATA_W-1:0]  height_reg;
    int                     fails = 0;
    int                     queued = 0;

    assign err_count = fails;
    assign pending   = queued;

    function automatic int unsigned frame_cols();
        int unsigned w;
        w = width_reg;
        if (w < MIN_DIM) w = MIN_DIM;
        if (w > MAX_COLS) w = MAX_COLS;
        return w;
    endfunction

    function automatic int unsigned frame_rows();
        int unsigned h;
        h = height_reg;
        if (h < MIN_DIM) h = MIN_DIM;
        if (h > MAX_ROWS) h = MAX_ROWS;
        return h;
    endfunction

    function automatic logic [PIX_W-1:0] median_of_nine();
        logic signed [PIX_W-1:0] s [WIN_TAPS];
        logic signed [PIX_W-1:0] t;
        for (int i = 0; i < WIN_TAPS; i++) s[i] = taps[i];
        for (int i = 0; i < WIN_TAPS; i++) begin
            for (int j = i + 1; j < WIN_TAPS; j++) begin
                if (s[i] > s[j])
                begin
                    t    = s[i];
                    s[i] = s[j];
                    s[j] = t;
                end
            end
        end
        return s[WIN_TAPS / 2];
    endfunction

    task automatic take_pixel(input logic [PIX_W-1:0] px);
        int unsigned  w;
        int unsigned  h;
        int unsigned  c;
        int unsigned  r;
        median_item_t exp_item;
        w = frame_cols();
        h = frame_rows();
        // counters left past a shrunken frame wrap here
        if (col_pos >= w)
        begin
            col_pos = 0;
            row_pos++;
        end
        if (row_pos >= h) row_pos = 0;
        c = col_pos;
        r = row_pos;

        for (int i = 0; i < WIN_SIZE; i++) begin
            taps[i * WIN_SIZE]     = taps[i * WIN_SIZE + 1];
            taps[i * WIN_SIZE + 1] = taps[i * WIN_SIZE + 2];
        end
        taps[2]       = row_above2[c];
        taps[5]       = row_above1[c];
        taps[8]       = px;
        row_above2[c] = row_above1[c];
        row_above1[c] = px;

        if (r >= EMIT_START && c >= EMIT_START)
        begin
            exp_item.value = median_of_nine();
            exp_item.row   = OUT_ROW_W'(r - EMIT_START);
            exp_item.col   = OUT_COL_W'(c - EMIT_START);
            exp_item.last  = (r == h - 1) && (c == w - 1);
            median_q.push_back(exp_item);
        end

        col_pos = c + 1;
        if (col_pos >= w)
        begin
            col_pos = 0;
            row_pos = r + 1;
            if (row_pos >= h) row_pos = 0;
        end
    endtask

    task automatic compare_field(input string name, input logic [PIX_W-1:0] exp_v,
                                 input logic [PIX_W-1:0] act_v);
        if (exp_v !== act_v)
        begin
            fails++;
            $display("%0t: %s expected %0h actual %0h", $time, name, exp_v, act_v);
        end
    endtask

    task automatic check_result();
        median_item_t exp_item;
        if (median_q.size() == 0)
        begin
            fails++;
            $display("%0t: result item with none expected, expected nothing actual %h last %b",
                     $time, m_tdata, m_tlast);
        end
        else
        begin
            exp_item = median_q.pop_front();
            compare_field("median_value", exp_item.value, m_tdata[PIX_W-1:0]);
            compare_field("out_row", PIX_W'(exp_item.row), PIX_W'(m_tdata[ROW_LSB +: OUT_ROW_W]));
            compare_field("out_col", PIX_W'(exp_item.col), PIX_W'(m_tdata[COL_LSB +: OUT_COL_W]));
            compare_field("tdata pad", '0, PIX_W'(m_tdata[OUT_TDATA_W-1:PAD_LSB]));
            compare_field("frame_last", PIX_W'(exp_item.last), PIX_W'(m_tlast));
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            width_reg  = RST_IMAGE_WIDTH;
            height_reg = RST_IMAGE_HEIGHT;
            col_pos    = 0;
            row_pos    = 0;
            for (int i = 0; i < WIN_TAPS; i++) taps[i] = '0;
            for (int i = 0; i < MAX_COLS; i++) begin
                row_above2[i] = '0;
                row_above1[i] = '0;
            end
            median_q.delete();
            queued = 0;
        end
        else
        begin
            // a result always leaves after its pixel is accepted, so check first
            if (m_tvalid && m_tready) check_result();
            if (cfg_wr_en)
            begin
                case (cfg_addr)
                    CFG_IMAGE_WIDTH:  width_reg  = cfg_wdata[CFG_WIDTH_W-1:0];
                    CFG_IMAGE_HEIGHT: height_reg = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) take_pixel(s_tdata);
            queued = median_q.size();
        end
    end

endmodule

[dv/tb_median_filter_3x3_valid_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_median_filter_3x3_valid_unit
// Drives pixel frames of many sizes into the 3x3 median filter with random
// gaps and back-pressure, resizes the frame between frames and in the middle
// of one, and lets median_window_checker predict and compare every result.
// ----------------------------------------------------------------------------
module tb_median_filter_3x3_valid_unit;
    import mf3_pkg::*;

    localparam logic [PIX_W-1:0] PIX_MAX = 32'h7FFF_FFFF;
    localparam logic [PIX_W-1:0] PIX_MIN = 32'h8000_0000;
    localparam int RAND_ITEMS    = 1250;
    localparam int CALM_ITEMS    = 200;      // final stretch with no idling
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 10;       // pipeline is 5 deep
    localparam int TIMEOUT_NS    = 10_000_000;
    localparam int WIDE_EXTRA    = 6;        // pixels into row 1 of the wide frame
    localparam int NARROW_W      = 8;
    localparam int NARROW_H      = 4;

    logic                    clk       = 1'b0;
    logic                    rst_n     = 1'b0;
    logic                    cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0]   cfg_addr  = '0;
    logic [CFG_DATA_W-1:0]   cfg_wdata = '0;
    logic                    s_tvalid  = 1'b0;
    logic                    s_tready;
    logic [PIX_W-1:0]        s_tdata   = '0;
    logic                    m_tvalid;
    logic                    m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0]  m_tdata;
    logic                    m_tlast;
    int                      err_count;
    int                      pending;
    bit                      idle_on   = 1'b1;
    bit                      hold_req  = 1'b0;

    median_filter_3x3_valid_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    median_window_checker chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .err_count (err_count),
        .pending   (pending)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [PIX_W-1:0] extreme_pixel(input int k);
        case (k % 8)
            0:       return PIX_MAX;
            1:       return PIX_MIN;
            2:       return '0;
            3:       return '1;
            4:       return 32'd1;
            5:       return PIX_MAX - 32'd1;
            6:       return PIX_MIN + 32'd1;
            default: return 32'h5555_5555 ^ {32{k[3]}};
        endcase
    endfunction

    function automatic logic [PIX_W-1:0] pick_pixel();
        case ($urandom_range(0, 5))
            0:       return extreme_pixel($urandom_range(0, 15));
            1:       return $urandom_range(0, 15) - 32'd8;   // ties around zero
            2:       return PIX_MAX - $urandom_range(0, 3);
            3:       return PIX_MIN + $urandom_range(0, 3);
            default: return $urandom();
        endcase
    endfunction

    function automatic int eff_cols(input logic [CFG_DATA_W-1:0] raw);
        int w;
        w = raw[CFG_WIDTH_W-1:0];
        if (w < MIN_DIM) w = MIN_DIM;
        if (w > DEF_MAX_COLS) w = DEF_MAX_COLS;
        return w;
    endfunction

    function automatic int eff_rows(input logic [CFG_DATA_W-1:0] raw);
        int h;
        h = raw;
        if (h < MIN_DIM) h = MIN_DIM;
        return h;
    endfunction

    // called and returns at a falling edge
    task automatic send_pixel(input logic [PIX_W-1:0] px);
        if (idle_on && $urandom_range(0, 6) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic feed(input int n);
        repeat (n) send_pixel(pick_pixel());
    endtask

    // wait until every result is out and the pipe has drained
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_cfg(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_size(input logic [CFG_DATA_W-1:0] w_raw,
                            input logic [CFG_DATA_W-1:0] h_raw);
        settle();
        write_cfg(CFG_IMAGE_WIDTH, w_raw);
        write_cfg(CFG_IMAGE_HEIGHT, h_raw);
    endtask

    // result side: random stalls, plus one long hold-off on request
    initial begin
        forever begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                m_tready <= 1'b1;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(negedge clk);
                m_tready <= 1'b1;
            end
            else
                m_tready <= 1'b1;
        end
    end

    initial begin
        logic [CFG_DATA_W-1:0] w_raw;
        logic [CFG_DATA_W-1:0] h_raw;
        logic [CFG_DATA_W-1:0] w2_raw;
        logic [CFG_DATA_W-1:0] h2_raw;
        int                    n_rows;
        int                    n_cols;
        int                    rand_items;
        int                    frame_no;
        rand_items = 0;
        frame_no   = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // undersized registers act as the 3x3 minimum; first frame after reset
        set_size(16'd1, 16'd0);
        for (int k = 0; k < 9; k++) send_pixel(extreme_pixel(k));

        // stop inside row 3 of a 4x5 frame, then shrink to 3x3: column and
        // row counters both sit past the new size and wrap on the next item
        set_size(16'd4, 16'd5);
        for (int k = 0; k < 15; k++) send_pixel(extreme_pixel(3 * k + 1));
        set_size(16'd3, 16'd3);
        for (int k = 0; k < 9; k++) send_pixel(extreme_pixel(k + 5));

        while (rand_items < RAND_ITEMS) begin
            idle_on = (rand_items < RAND_ITEMS - CALM_ITEMS) && ($urandom_range(0, 4) != 0);
            if (frame_no == 2)
            begin
                // long receiver hold-off while the frame keeps coming
                set_size(16'd10, 16'd8);
                hold_req = 1'b1;
                feed(80);
                rand_items += 80;
            end
            else if (frame_no == 3)
            begin
                // oversized width acts as the widest row: one full row and a
                // few pixels, then narrow the frame and finish it
                set_size(16'h07FF, CFG_DATA_W'(NARROW_H));
                feed(DEF_MAX_COLS + WIDE_EXTRA);
                set_size(CFG_DATA_W'(NARROW_W), CFG_DATA_W'(NARROW_H));
                feed(NARROW_W - WIDE_EXTRA + (NARROW_H - 2) * NARROW_W);
                rand_items += DEF_MAX_COLS + NARROW_W + (NARROW_H - 2) * NARROW_W;
            end
            else
            begin
                case ($urandom_range(0, 9))
                    0:
                    begin
                        // shrink the width and lower or keep the height in the middle of a row
                        w_raw  = CFG_DATA_W'($urandom_range(4, 9));
                        h_raw  = CFG_DATA_W'($urandom_range(4, 6));
                        n_rows = $urandom_range(2, h_raw - 1);
                        n_cols = $urandom_range(3, w_raw - 1);
                        set_size(w_raw, h_raw);
                        feed(n_rows * w_raw + n_cols);
                        w2_raw = CFG_DATA_W'($urandom_range(0, n_cols));
                        h2_raw = CFG_DATA_W'($urandom_range(0, n_rows + 1));
                        set_size(w2_raw, h2_raw);
                        feed(eff_cols(w2_raw) * eff_rows(h2_raw));
                        rand_items += n_rows * w_raw + n_cols
                                      + eff_cols(w2_raw) * eff_rows(h2_raw);
                    end
                    1:
                    begin
                        // very tall frame cut short by lowering the height
                        w_raw  = CFG_DATA_W'($urandom_range(3, 8));
                        h_raw  = ($urandom_range(0, 1) == 0)
                                 ? 16'hFFFF : CFG_DATA_W'($urandom_range(6, 16'hFFFE));
                        n_rows = $urandom_range(3, 5);
                        set_size(w_raw, h_raw);
                        feed(n_rows * w_raw);
                        h2_raw = CFG_DATA_W'($urandom_range(3, n_rows));
                        set_size(w_raw, h2_raw);
                        feed(w_raw * h2_raw);
                        rand_items += n_rows * w_raw + w_raw * h2_raw;
                    end
                    default:
                    begin
                        w_raw = CFG_DATA_W'($urandom_range(3, 10));
                        h_raw = CFG_DATA_W'($urandom_range(3, 6));
                        if ($urandom_range(0, 7) == 0) w_raw = CFG_DATA_W'($urandom_range(0, 2));
                        if ($urandom_range(0, 7) == 0) h_raw = CFG_DATA_W'($urandom_range(0, 2));
                        // junk above the 11-bit width field
                        if ($urandom_range(0, 3) == 0)
                            w_raw[CFG_DATA_W-1:CFG_WIDTH_W] =
                                (CFG_DATA_W - CFG_WIDTH_W)'($urandom());
                        set_size(w_raw, h_raw);
                        feed(eff_cols(w_raw) * eff_rows(h_raw));
                        rand_items += eff_cols(w_raw) * eff_rows(h_raw);
                    end
                endcase
            end
            frame_no++;
        end

        idle_on = 1'b0;
        settle();
        if (err_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
